// ===== rtl/tksd_pkg.sv =====
package tksd_pkg;

   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_O     = 8'd79;
   localparam logic [7:0] BYTE_F     = 8'h46;
   localparam logic [7:0] BYTE_BR    = 8'd91;
   localparam logic [7:0] BYTE_TILDE = 8'd126;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ESC     = 3'd1,
      PH_ESC_O   = 3'd2,
      PH_ESC_BR  = 3'd3,
      PH_ESC_NUM = 3'd4
   } phase_type;

   typedef enum logic [4:0] {
      K_PRINT  = 5'd0,
      K_ESC    = 5'd1,
      K_UNK    = 5'd2,
      K_END    = 5'd3,
      K_INS    = 5'd4,
      K_UP     = 5'd5,
      K_DOWN   = 5'd6,
      K_RIGHT  = 5'd7,
      K_LEFT   = 5'd8,
      K_HOME   = 5'd9,
      K_PGDN   = 5'd10,
      K_PGUP   = 5'd11,
      K_DEL    = 5'd12,
      K_ENTER  = 5'd13,
      K_TAB    = 5'd14,
      K_BKSP   = 5'd15,
      K_CTRL_Z = 5'd16,
      K_CTRL_A = 5'd17,
      K_CTRL_E = 5'd18,
      K_CTRL_C = 5'd19,
      K_CTRL_T = 5'd20,
      K_CTRL_U = 5'd21,
      K_CTRL_K = 5'd22,
      K_CTRL_L = 5'd23,
      K_CTRL_D = 5'd24
   } key_code_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] held_digit;
      logic       drop_next_lf;
   } dec_state_type;

   localparam dec_state_type STATE_RESET = '{phase: PH_IDLE, held_digit: 3'd0,
                                             drop_next_lf: 1'b0};

   typedef struct packed {
      logic         emit;
      key_code_type key_code;
      logic [6:0]   char_value;
   } dec_result_type;

   typedef struct packed {
      logic       is_gap;
      logic [7:0] rx_byte;
   } req_item_type;

   function automatic key_code_type map_control(input logic [7:0] b);
      key_code_type k;
      case (b)
         BYTE_TAB: k = K_TAB;
         BYTE_DEL: k = K_DEL;
         BYTE_BS:  k = K_BKSP;
         8'd26:    k = K_CTRL_Z;
         8'd1:     k = K_CTRL_A;
         8'd5:     k = K_CTRL_E;
         8'd3:     k = K_CTRL_C;
         8'd20:    k = K_CTRL_T;
         8'd21:    k = K_CTRL_U;
         8'd11:    k = K_CTRL_K;
         8'd12:    k = K_CTRL_L;
         8'd4:     k = K_CTRL_D;
         default:  k = K_UNK;
      endcase
      return k;
   endfunction

   function automatic key_code_type map_bracket_letter(input logic [7:0] b);
      key_code_type k;
      case (b)
         8'h40:   k = K_INS;
         8'h41:   k = K_UP;
         8'h42:   k = K_DOWN;
         8'h43:   k = K_RIGHT;
         8'h44:   k = K_LEFT;
         8'h48:   k = K_HOME;
         8'h55:   k = K_PGDN;
         8'h56:   k = K_PGUP;
         default: k = K_UNK;
      endcase
      return k;
   endfunction

   function automatic key_code_type map_tilde_digit(input logic [2:0] d);
      key_code_type k;
      case (d)
         3'd1:    k = K_HOME;
         3'd2:    k = K_INS;
         3'd3:    k = K_DEL;
         3'd4:    k = K_END;
         3'd5:    k = K_PGUP;
         3'd6:    k = K_PGDN;
         default: k = K_UNK;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/tksd_if.sv =====
interface tksd_req_if;
   logic       valid;
   logic       ready;
   logic       is_gap;
   logic [7:0] rx_byte;

   modport source (output valid, output is_gap, output rx_byte, input ready);
   modport sink (input valid, input is_gap, input rx_byte, output ready);
endinterface

interface tksd_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] key_code;
   logic [6:0] char_value;

   modport source (output valid, output key_code, output char_value, input ready);
   modport sink (input valid, input key_code, input char_value, output ready);
endinterface

// ===== rtl/terminal_key_sequence_decoder_unit.sv =====
// Terminal key decoder: takes one received byte or gap marker per transfer and
// gives at most one key code per item. An item is taken every cycle while the
// result side keeps up; the path runs through the input register, then the
// decode and parser state update into the result register. A stalled result
// holds the input register, and that in turn stalls the request side.
module terminal_key_sequence_decoder_unit (
   input logic       clock,
   input logic       reset,
   tksd_req_if.sink  req_ch,
   tksd_rsp_if.source rsp_ch
);
   import tksd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_item_type   in_ff;
   dec_state_type  state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_ff;

   dec_state_type  dec_next;
   dec_result_type dec_result;
   logic           out_free;
   logic           consume;
   logic           req_take;
   logic           load_out;

   tksd_decode u_decode (
      .state      (state_ff),
      .item       (in_ff),
      .state_next (dec_next),
      .result     (dec_result)
   );

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign consume      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign load_out     = consume && dec_result.emit;

   assign in_valid_in  = req_take || (in_valid_ff && !consume);
   assign state_in     = consume ? dec_next : state_ff;
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_ff.is_gap  <= req_ch.is_gap;
         in_ff.rx_byte <= req_ch.rx_byte;
      end
      if (load_out) out_ff <= dec_result;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.key_code   = out_ff.key_code;
   assign rsp_ch.char_value = out_ff.char_value;

`ifndef SYNTH
   a_char_only_printable: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.key_code != K_PRINT |-> out_ff.char_value == 7'd0)
      else $error("character set on a non-printable key");

   a_lf_drop_from_cr: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.drop_next_lf) |->
         $past(consume && !in_ff.is_gap && in_ff.rx_byte == BYTE_CR))
      else $error("lf drop armed without a cr");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_ESC_NUM |->
         state_ff.held_digit != 3'd0 && state_ff.held_digit != 3'd7)
      else $error("held digit out of range");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(consume))
      else $error("result appeared without a decoded item");

   a_state_only_on_consume: assert property (@(posedge clock) disable iff (reset)
      !consume |=> state_ff == $past(state_ff))
      else $error("parser state moved without an item");
`endif

endmodule

// ===== rtl/tksd_decode.sv =====
module tksd_decode (
   input  tksd_pkg::dec_state_type  state,
   input  tksd_pkg::req_item_type   item,
   output tksd_pkg::dec_state_type  state_next,
   output tksd_pkg::dec_result_type result
);
   import tksd_pkg::*;

   logic [7:0] b;

   assign b = item.rx_byte;

   always_comb begin
      state_next = state;
      result     = '{emit: 1'b0, key_code: K_UNK, char_value: 7'd0};
      state_next.phase = PH_IDLE;
      case (state.phase)
         PH_ESC: begin
            if (item.is_gap) begin
               result.emit     = 1'b1;
               result.key_code = K_ESC;
            end else if (b == BYTE_O) begin
               state_next.phase = PH_ESC_O;
            end else if (b == BYTE_BR) begin
               state_next.phase = PH_ESC_BR;
            end else begin
               result.emit = 1'b1;
            end
         end
         PH_ESC_O: begin
            result.emit = 1'b1;
            if (!item.is_gap && b == BYTE_F) result.key_code = K_END;
         end
         PH_ESC_BR: begin
            if (item.is_gap) begin
               result.emit = 1'b1;
            end else if (b inside {[8'h40:8'h56]}) begin
               result.emit     = 1'b1;
               result.key_code = map_bracket_letter(b);
            end else if (b inside {[8'h31:8'h36]}) begin
               state_next.phase      = PH_ESC_NUM;
               state_next.held_digit = 3'(b - BYTE_ZERO);
            end else begin
               result.emit = 1'b1;
            end
         end
         PH_ESC_NUM: begin
            result.emit = 1'b1;
            if (!item.is_gap && b == BYTE_TILDE)
               result.key_code = map_tilde_digit(state.held_digit);
         end
         default: begin
            // idle, and unused phase codes behave the same
            if (!item.is_gap) begin
               state_next.drop_next_lf = 1'b0;
               if (state.drop_next_lf && b == BYTE_LF) begin
                  result.emit = 1'b0;
               end else if (b inside {[8'h20:8'h7E]}) begin
                  result.emit       = 1'b1;
                  result.key_code   = K_PRINT;
                  result.char_value = b[6:0];
               end else if (b == BYTE_ESC) begin
                  state_next.phase = PH_ESC;
               end else if (b == BYTE_CR) begin
                  state_next.drop_next_lf = 1'b1;
                  result.emit             = 1'b1;
                  result.key_code         = K_ENTER;
               end else if (b == BYTE_LF) begin
                  result.emit     = 1'b1;
                  result.key_code = K_ENTER;
               end else begin
                  result.emit     = 1'b1;
                  result.key_code = map_control(b);
               end
            end
         end
      endcase
   end

endmodule

// ===== bench/tb_terminal_key_sequence_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_terminal_key_sequence_decoder_unit;
   import tksd_pkg::*;

   typedef struct packed {
      key_code_type key;
      logic [6:0]   ch;
   } key_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tksd_req_if req_if ();
   tksd_rsp_if rsp_if ();

   terminal_key_sequence_decoder_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   logic         send_valid = 1'b0;
   req_item_type send_item  = '0;
   logic         take_ready = 1'b0;

   assign req_if.valid   = send_valid;
   assign req_if.is_gap  = send_item.is_gap;
   assign req_if.rx_byte = send_item.rx_byte;
   assign rsp_if.ready   = take_ready;

   req_item_type  byte_queue[$];
   key_event_type key_fifo[$];

   // decoder state as the bench sees it
   phase_type  parse_q   = PH_IDLE;
   logic [2:0] digit_q   = 3'd0;
   logic       lf_drop_q = 1'b0;

   int   send_idle_pct = 19;
   int   recv_idle_pct = 54;
   logic rsp_hold      = 1'b0;
   logic hold_go       = 1'b0;
   int   mismatch_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_key(input req_item_type it, output bit emits,
                                       output key_event_type ev);
      phase_type  ph;
      logic [7:0] b;
      ph     = parse_q;
      b      = it.rx_byte;
      emits  = 1'b1;
      ev.key = K_UNK;
      ev.ch  = '0;
      parse_q = PH_IDLE;
      if (ph != PH_IDLE) begin
         if (it.is_gap) begin
            if (ph == PH_ESC) ev.key = K_ESC;
         end else begin
            case (ph)
               PH_ESC: begin
                  if (b == BYTE_O) begin
                     parse_q = PH_ESC_O;
                     emits   = 1'b0;
                  end else if (b == BYTE_BR) begin
                     parse_q = PH_ESC_BR;
                     emits   = 1'b0;
                  end
               end
               PH_ESC_O: begin
                  if (b == BYTE_F) ev.key = K_END;
               end
               PH_ESC_BR: begin
                  case (b)
                     8'h40: ev.key = K_INS;
                     8'h41: ev.key = K_UP;
                     8'h42: ev.key = K_DOWN;
                     8'h43: ev.key = K_RIGHT;
                     8'h44: ev.key = K_LEFT;
                     8'h48: ev.key = K_HOME;
                     8'h55: ev.key = K_PGDN;
                     8'h56: ev.key = K_PGUP;
                     default: begin
                        // digits 1..6 open a tilde sequence
                        if (b > BYTE_ZERO && b < BYTE_ZERO + 8'd7) begin
                           digit_q = 3'(b - BYTE_ZERO);
                           parse_q = PH_ESC_NUM;
                           emits   = 1'b0;
                        end
                     end
                  endcase
               end
               default: begin
                  if (b == BYTE_TILDE) begin
                     case (digit_q)
                        3'd1:    ev.key = K_HOME;
                        3'd2:    ev.key = K_INS;
                        3'd3:    ev.key = K_DEL;
                        3'd4:    ev.key = K_END;
                        3'd5:    ev.key = K_PGUP;
                        3'd6:    ev.key = K_PGDN;
                        default: ev.key = K_UNK;
                     endcase
                  end
               end
            endcase
         end
      end else if (it.is_gap) begin
         emits = 1'b0;
      end else if (lf_drop_q && b == BYTE_LF) begin
         lf_drop_q = 1'b0;
         emits     = 1'b0;
      end else begin
         lf_drop_q = 1'b0;
         if (b >= 8'h20 && b <= 8'h7E) begin
            ev.key = K_PRINT;
            ev.ch  = b[6:0];
         end else begin
            case (b)
               BYTE_ESC: begin
                  parse_q = PH_ESC;
                  emits   = 1'b0;
               end
               BYTE_CR: begin
                  lf_drop_q = 1'b1;
                  ev.key    = K_ENTER;
               end
               BYTE_LF:  ev.key = K_ENTER;
               BYTE_TAB: ev.key = K_TAB;
               BYTE_DEL: ev.key = K_DEL;
               BYTE_BS:  ev.key = K_BKSP;
               8'd26:    ev.key = K_CTRL_Z;
               8'd1:     ev.key = K_CTRL_A;
               8'd5:     ev.key = K_CTRL_E;
               8'd3:     ev.key = K_CTRL_C;
               8'd20:    ev.key = K_CTRL_T;
               8'd21:    ev.key = K_CTRL_U;
               8'd11:    ev.key = K_CTRL_K;
               8'd12:    ev.key = K_CTRL_L;
               8'd4:     ev.key = K_CTRL_D;
               default:  ev.key = K_UNK;
            endcase
         end
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] b);
      req_item_type it;
      it.is_gap  = 1'b0;
      it.rx_byte = b;
      byte_queue.push_back(it);
   endfunction

   function automatic void queue_gap();
      req_item_type it;
      it.is_gap  = 1'b1;
      it.rx_byte = 8'($urandom);
      byte_queue.push_back(it);
   endfunction

   // mostly well-formed key sequences with random content, some noise
   function automatic void add_random_burst();
      int         pick;
      logic [7:0] d;
      pick = $urandom_range(99);
      if (pick < 28) begin
         queue_byte(8'($urandom_range(8'h7E, 8'h20)));
      end else if (pick < 42) begin
         queue_byte(8'($urandom_range(8'h1F, 8'h00)));
      end else if (pick < 48) begin
         queue_byte(8'($urandom));
      end else if (pick < 52) begin
         queue_gap();
      end else if (pick < 60) begin
         queue_byte(BYTE_CR);
         if ($urandom_range(2) != 0) queue_byte(BYTE_LF);
      end else begin
         queue_byte(BYTE_ESC);
         pick = $urandom_range(99);
         if (pick < 8) begin
            queue_gap();
         end else if (pick < 20) begin
            queue_byte(BYTE_O);
            pick = $urandom_range(9);
            if (pick < 7) queue_byte(BYTE_F);
            else if (pick < 9) queue_byte(8'($urandom));
            else queue_gap();
         end else if (pick < 88) begin
            queue_byte(BYTE_BR);
            pick = $urandom_range(99);
            if (pick < 45) begin
               queue_byte(8'($urandom_range(8'h56, 8'h40)));
            end else if (pick < 92) begin
               // digits 0 and 7 are outside the tilde set
               d = BYTE_ZERO + 8'($urandom_range(7));
               queue_byte(d);
               if (d > BYTE_ZERO && d < BYTE_ZERO + 8'd7) begin
                  pick = $urandom_range(9);
                  if (pick < 7) queue_byte(BYTE_TILDE);
                  else if (pick < 9) queue_byte(8'($urandom));
                  else queue_gap();
               end
            end else if (pick < 96) begin
               queue_byte(8'($urandom));
            end else begin
               queue_gap();
            end
         end else begin
            queue_byte(8'($urandom));
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, what);
   endtask

   task automatic wait_drain();
      while (byte_queue.size() != 0 || send_valid || key_fifo.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         send_valid <= 1'b0;
      end else if (!send_valid || req_if.ready) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = byte_queue.pop_front();
            send_valid <= 1'b1;
            send_item  <= it;
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) take_ready <= 1'b0;
      else take_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // result check first, then the prediction for an input transfer at this edge
   always @(posedge clock) begin
      key_event_type want;
      key_event_type ev;
      bit            emits;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (key_fifo.size() == 0) begin
               report_mismatch($sformatf("unexpected key %0d char %0d",
                                         rsp_if.key_code, rsp_if.char_value));
            end else begin
               want = key_fifo.pop_front();
               if (rsp_if.key_code != want.key || rsp_if.char_value != want.ch)
                  report_mismatch($sformatf("expected key %0d char %0d, got key %0d char %0d",
                                            want.key, want.ch, rsp_if.key_code,
                                            rsp_if.char_value));
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_key(send_item, emits, ev);
            if (emits) key_fifo.push_back(ev);
         end
      end
   end

   initial begin : rsp_hold_off
      int n;
      while (!hold_go) @(posedge clock);
      rsp_hold <= 1'b1;
      for (n = 0; n < 120; n++) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : stimulus
      int p;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, line endings, each sequence shape
      queue_gap();
      queue_byte(8'h20);
      queue_byte(8'h7E);
      queue_byte(BYTE_DEL);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(BYTE_CR);
      queue_byte(BYTE_LF);
      queue_byte(BYTE_LF);
      queue_byte(BYTE_ESC);
      queue_gap();
      queue_byte(BYTE_ESC);
      queue_byte(BYTE_BR);
      queue_byte(8'h41);
      queue_byte(BYTE_ESC);
      queue_byte(BYTE_BR);
      queue_byte(BYTE_ZERO + 8'd3);
      queue_byte(BYTE_TILDE);
      queue_byte(BYTE_ESC);
      queue_byte(BYTE_O);
      queue_byte(BYTE_F);
      queue_byte(BYTE_ESC);
      queue_byte(BYTE_BR);
      queue_gap();
      queue_byte(BYTE_ESC);
      queue_byte(8'h41);

      for (p = 0; p < 3; p++) begin
         if (p == 1) begin
            send_idle_pct <= 54;
            recv_idle_pct <= 19;
         end else if (p == 2) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         while (byte_queue.size() < 500) add_random_burst();
         // long receiver stall with the sender still offering
         if (p == 2) hold_go <= 1'b1;
         // no new bytes are queued until the queue is sent and every key has come back
         wait_drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
